>>> rtl/rrft_pkg.sv
`timescale 1ns / 1ps

package rrft_pkg;

  // Fixed field widths of the transaction ports
  localparam int ID_W     = 10;
  localparam int PG_W     = 10;
  localparam int BEHIND_W = 10;
  localparam int ID_SPACE = 2 ** ID_W;

  // Command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_BUB_PG,
    S_BUB_CMP,
    S_FINAL,
    S_SC_PG,
    S_SC_CMP,
    S_DIV
  } state_t;

endpackage

>>> rtl/rrft_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// quotient = (dividend << FB) / divisor; caller keeps dividend <= divisor.
module rrft_div #(
  parameter int CW = 11,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [FB:0]   quotient
);

  localparam int NB    = CW + FB;
  localparam int CNT_W = $clog2(NB + 1);

  logic [NB-1:0]    num_r, num_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  logic [CW:0] trial;
  logic [CW:0] diff;
  logic        fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, num_r[NB-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = {dividend, {FB{1'b0}}};
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(NB);
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[NB-2:0], fits};
      rem_nxt = fits ? diff[CW-1:0] : trial[CW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r[FB:0];

endmodule

>>> rtl/reader_rank_fraction_table.sv
`timescale 1ns / 1ps
// Record: the count is stored and the user climbs the list past entries with fewer pages;
//   a record with zero pages, or from a new user when the table is full, is dropped.
// Query: scans the list entries tied with the user's count, then divides the users behind
//   by the other users; result strobed as busy falls; absent user: no result; lone user: 1.0.
// Reset (rst_n low, synchronous) starts a clearing pass over all min(MAX_USERS,1024) entries
//   of the page-count memory, busy high. Results are strobed once; no stall possible.
module reader_rank_fraction_table
  import rrft_pkg::*;
#(
  parameter int MAX_USERS     = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [ID_W-1:0]          in_user_id,
  input  logic [PG_W-1:0]          in_page_count,
  output logic                     out_valid,
  output logic [FRACTION_BITS:0]   out_fraction_q16,
  output logic [BEHIND_W-1:0]      out_users_behind
);

  // Only ids below both MAX_USERS and the id space can ever be addressed
  localparam int UD = (MAX_USERS < ID_SPACE) ? MAX_USERS : ID_SPACE;
  localparam int AW = $clog2(UD);
  localparam int CW = $clog2(UD + 1);

  state_t state_r, state_nxt;

  logic [AW-1:0]        clr_r, clr_nxt;
  logic [CW-1:0]        active_r, active_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [AW-1:0]        user_r, user_nxt;
  logic [PG_W-1:0]      pages_r, pages_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        prev_r, prev_nxt;
  logic [CW-1:0]        behind_r, behind_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [FRACTION_BITS:0] ofrac_r, ofrac_nxt;
  logic [BEHIND_W-1:0]  obehind_r, obehind_nxt;

  // Memory ports
  logic [PG_W-1:0] pg_mem [UD];
  logic [AW-1:0]   rk_mem [UD];
  logic [AW-1:0]   ro_mem [UD];

  logic            pg_we, rk_we, ro_we;
  logic [AW-1:0]   pg_waddr, pg_raddr, rk_waddr, rk_raddr, ro_waddr, ro_raddr;
  logic [PG_W-1:0] pg_wdata, pg_rdata;
  logic [AW-1:0]   rk_wdata, rk_rdata, ro_wdata, ro_rdata;

  // Divider
  logic                   div_start;
  logic [CW-1:0]          div_dividend;
  logic                   div_done;
  logic [FRACTION_BITS:0] div_q;

  // Helper terms
  logic          accept;
  logic          id_ok;
  logic          is_new;
  logic [CW-1:0] rec_pos;
  logic [CW-1:0] pos_inc;

  assign accept  = start && (state_r == S_IDLE);
  assign id_ok   = int'(in_user_id) < UD;
  assign is_new  = (pg_rdata == '0);
  assign rec_pos = is_new ? active_r : CW'(ro_rdata);
  assign pos_inc = pos_r + CW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(UD - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start && id_ok) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_RECORD) begin
          if (pages_r == '0 || (is_new && active_r >= CW'(UD))) begin
            state_nxt = S_IDLE;
          end else if (rec_pos != '0) begin
            state_nxt = S_BUB_PG;
          end else begin
            state_nxt = S_FINAL;
          end
        end else begin
          if (is_new || active_r <= CW'(1)) state_nxt = S_IDLE;
          else state_nxt = S_SC_PG;
        end
      end
      S_BUB_PG: state_nxt = S_BUB_CMP;
      S_BUB_CMP: begin
        if (pages_r > pg_rdata && pos_r > CW'(1)) state_nxt = S_BUB_PG;
        else state_nxt = S_FINAL;
      end
      S_FINAL: state_nxt = S_IDLE;
      S_SC_PG: state_nxt = S_SC_CMP;
      S_SC_CMP: begin
        if (pg_rdata == pages_r && pos_inc < active_r) state_nxt = S_SC_PG;
        else state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result registers
  always_comb begin
    clr_nxt      = clr_r;
    active_nxt   = active_r;
    cmd_nxt      = cmd_r;
    user_nxt     = user_r;
    pages_nxt    = pages_r;
    pos_nxt      = pos_r;
    prev_nxt     = prev_r;
    behind_nxt   = behind_r;
    ovalid_nxt   = 1'b0;
    ofrac_nxt    = ofrac_r;
    obehind_nxt  = obehind_r;
    pg_we        = 1'b0;
    pg_waddr     = user_r;
    pg_wdata     = pages_r;
    pg_raddr     = user_r;
    rk_we        = 1'b0;
    rk_waddr     = pos_r[AW-1:0];
    rk_wdata     = prev_r;
    rk_raddr     = pos_r[AW-1:0];
    ro_we        = 1'b0;
    ro_waddr     = prev_r;
    ro_wdata     = pos_r[AW-1:0];
    ro_raddr     = user_r;
    div_start    = 1'b0;
    div_dividend = behind_r;
    case (state_r)
      S_CLEAR: begin
        pg_we    = 1'b1;
        pg_waddr = clr_r;
        pg_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
      end
      S_IDLE: begin
        // Look up the user's count and list place in the same cycle
        pg_raddr = in_user_id[AW-1:0];
        ro_raddr = in_user_id[AW-1:0];
        if (accept) begin
          cmd_nxt   = in_command;
          user_nxt  = in_user_id[AW-1:0];
          pages_nxt = in_page_count;
        end
      end
      S_CHECK: begin
        if (cmd_r == CMD_RECORD) begin
          if (!(pages_r == '0 || (is_new && active_r >= CW'(UD)))) begin
            // New users go to the tail; store the count and start climbing
            if (is_new) active_nxt = active_r + 1'b1;
            pg_we    = 1'b1;
            pos_nxt  = rec_pos;
            rk_raddr = AW'(rec_pos - CW'(1));
          end
        end else begin
          pages_nxt = pg_rdata;
          pos_nxt   = CW'(ro_rdata);
          rk_raddr  = ro_rdata;
          if (!is_new && active_r <= CW'(1)) begin
            // Only one user: full fraction
            ovalid_nxt  = 1'b1;
            ofrac_nxt   = {1'b1, {FRACTION_BITS{1'b0}}};
            obehind_nxt = '0;
          end
        end
      end
      S_BUB_PG: begin
        prev_nxt = rk_rdata;
        pg_raddr = rk_rdata;
      end
      S_BUB_CMP: begin
        // Swap past a neighbor with fewer pages; the user is written at the end
        if (pages_r > pg_rdata) begin
          rk_we    = 1'b1;
          ro_we    = 1'b1;
          pos_nxt  = pos_r - CW'(1);
          rk_raddr = AW'(pos_r - CW'(2));
        end
      end
      S_FINAL: begin
        rk_we    = 1'b1;
        rk_wdata = user_r;
        ro_we    = 1'b1;
        ro_waddr = user_r;
      end
      S_SC_PG: begin
        pg_raddr = rk_rdata;
      end
      S_SC_CMP: begin
        // Skip users tied with the queried count
        if (pg_rdata == pages_r) begin
          pos_nxt  = pos_inc;
          rk_raddr = pos_inc[AW-1:0];
          if (!(pos_inc < active_r)) begin
            behind_nxt   = '0;
            div_dividend = '0;
            div_start    = 1'b1;
          end
        end else begin
          behind_nxt   = active_r - pos_r;
          div_dividend = active_r - pos_r;
          div_start    = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ovalid_nxt  = 1'b1;
          ofrac_nxt   = div_q;
          obehind_nxt = BEHIND_W'(behind_r);
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      active_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    user_r    <= user_nxt;
    pages_r   <= pages_nxt;
    pos_r     <= pos_nxt;
    prev_r    <= prev_nxt;
    behind_r  <= behind_nxt;
    ofrac_r   <= ofrac_nxt;
    obehind_r <= obehind_nxt;
  end

  // Page count per user
  always_ff @(posedge clk) begin
    if (pg_we) pg_mem[pg_waddr] <= pg_wdata;
    pg_rdata <= pg_mem[pg_raddr];
  end

  // Users by descending count
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rdata <= rk_mem[rk_raddr];
  end

  // List place per user
  always_ff @(posedge clk) begin
    if (ro_we) ro_mem[ro_waddr] <= ro_wdata;
    ro_rdata <= ro_mem[ro_raddr];
  end

  rrft_div #(
    .CW (CW),
    .FB (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (active_r - CW'(1)),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_fraction_q16 = ofrac_r;
  assign out_users_behind = obehind_r;

endmodule
